FILE: rtl/core/atb_pkg.sv
package atb_pkg;

  // Default configuration
  localparam int MaxEntriesDef = 64;
  localparam int FracBitsDef   = 16;

  // Fixed field widths
  localparam int WeightW = 16;
  localparam int CountW  = 7;
  localparam int SumW    = 22;
  localparam int IdxOutW = 6;
  localparam int ThrW    = 17;
  localparam int PtrW    = 7;
  localparam int ProdW   = 23;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_fire;
    logic idx_clr;
    logic idx_inc;
    logic w_rd;
    logic mul;
    logic div_start;
    logic sc_wr;
    logic pr_qrd;
    logic pr_prd;
    logic pr_wr;
    logic dr_qrd;
    logic dr_wr;
    logic em_rd;
    logic zero_out;
    logic clear;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_in;
    logic sum_zero;
    logic idx_last;
    logic div_done;
    logic small_empty;
    logic large_empty;
  } sts_t;

endpackage

FILE: rtl/core/atb_if.sv
interface atb_in_if;
  logic                        valid;
  logic                        ready;
  logic [atb_pkg::WeightW-1:0] weight;
  logic                        last_weight;

  modport source (output valid, weight, last_weight, input ready);
  modport sink (input valid, weight, last_weight, output ready);
endinterface

interface atb_out_if;
  logic                        valid;
  logic                        ready;
  logic [atb_pkg::IdxOutW-1:0] entry_index;
  logic [atb_pkg::ThrW-1:0]    threshold;
  logic [atb_pkg::IdxOutW-1:0] alias_index;
  logic                        last_entry;
  logic                        all_zero;
  logic                        overflowed;

  modport source (output valid, entry_index, threshold, alias_index, last_entry, all_zero,
                  overflowed, input ready);
  modport sink (input valid, entry_index, threshold, alias_index, last_entry, all_zero,
                overflowed, output ready);
endinterface

FILE: rtl/core/atb_div.sv
module atb_div #(
  parameter int DW = 39,
  parameter int QW = 23,
  parameter int SW = 22
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [SW-1:0] divisor_i,
  output logic          done_o,
  output logic [QW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [SW-1:0] rem_q;
  logic [DW-1:0] dvd_q;
  logic [QW-1:0] quo_q;
  logic [SW:0]   trial;
  logic          ge;

  // Trial subtract of one quotient bit
  assign trial = {rem_q, dvd_q[DW-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift remainder, dividend and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? SW'(trial - {1'b0, divisor_i}) : SW'(trial);
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

FILE: rtl/core/atb_datapath.sv
module atb_datapath #(
  parameter int MAX_ENTRIES   = atb_pkg::MaxEntriesDef,
  parameter int FRACTION_BITS = atb_pkg::FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  atb_pkg::cmd_t               cmd_i,
  output atb_pkg::sts_t               sts_o,
  input  logic [atb_pkg::WeightW-1:0] weight_i,
  input  logic                        last_weight_i,
  output logic [atb_pkg::IdxOutW-1:0] entry_index_o,
  output logic [atb_pkg::ThrW-1:0]    threshold_o,
  output logic [atb_pkg::IdxOutW-1:0] alias_index_o,
  output logic                        last_entry_o,
  output logic                        all_zero_o,
  output logic                        overflowed_o
);

  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int PW  = FRACTION_BITS + 7;
  localparam int DW  = atb_pkg::ProdW + FRACTION_BITS;
  localparam int CW  = atb_pkg::CountW;
  localparam int SW  = atb_pkg::SumW;
  localparam int TW  = atb_pkg::ThrW;
  localparam int QPW = atb_pkg::PtrW;
  localparam int SHR = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int SHL = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam logic [PW-1:0] OneP = PW'(1) << FRACTION_BITS;

  // Accumulation state
  logic [CW-1:0] count_q;
  logic [SW-1:0] sum_q, sum_d, sum_acc;
  logic          ovf_q;
  logic [CW-1:0] idx_q;
  logic          room;
  logic          store;

  // Storage
  logic [atb_pkg::WeightW-1:0] wmem [MAX_ENTRIES];
  logic [PW-1:0]               pmem [MAX_ENTRIES];
  logic [TW-1:0]               tmem [MAX_ENTRIES];
  logic [IW-1:0]               amem [MAX_ENTRIES];
  logic [IW-1:0]               smem [MAX_ENTRIES];
  logic [IW-1:0]               lmem [MAX_ENTRIES];

  // Read data
  logic [atb_pkg::WeightW-1:0] w_rd_q;
  logic [atb_pkg::ProdW-1:0]   prod_q;
  logic [PW-1:0]               ps_q, pl_q;
  logic [IW-1:0]               s_rd_q, l_rd_q;
  logic [TW-1:0]               t_rd_q;
  logic [IW-1:0]               a_rd_q;
  logic                        drain_large_q;

  // Queue pointers and their slots
  logic [QPW-1:0] sh_q, st_q, lh_q, lt_q;
  logic [IW-1:0]  shs_q, sts_q, lhs_q, lts_q;

  logic          div_done;
  logic [PW-1:0] div_q;
  logic [PW-1:0] pnew;
  logic [IW-1:0] idx_a, drain_e;
  logic          push_en, push_large;
  logic [IW-1:0] push_val;
  logic          pop_small, pop_large;
  logic          s_empty, l_empty;

  function automatic logic [TW-1:0] to_thr(logic [PW-1:0] p);
    logic [PW+15:0] wide;
    wide = (PW + 16)'(p);
    return TW'((wide >> SHR) << SHL);
  endfunction

  // Advance a queue slot alongside its 7-bit pointer
  function automatic logic [IW-1:0] slot_inc(logic [QPW-1:0] ptr, logic [IW-1:0] slot);
    logic [IW-1:0] r;
    if (ptr == {QPW{1'b1}}) r = '0;
    else if (slot == IW'(MAX_ENTRIES - 1)) r = '0;
    else r = slot + IW'(1);
    return r;
  endfunction

  assign idx_a = idx_q[IW-1:0];
  assign room = (count_q < CW'(MAX_ENTRIES));
  assign store = cmd_i.load_fire && room;
  // Sum including the offered weight, dropped when full
  assign sum_acc = room ? sum_q + SW'(weight_i) : sum_q;
  assign sum_d = store ? sum_acc : sum_q;
  assign s_empty = (sh_q == st_q);
  assign l_empty = (lh_q == lt_q);
  assign pnew = pl_q + ps_q - OneP;
  assign drain_e = drain_large_q ? l_rd_q : s_rd_q;

  // Push and pop selection
  always_comb begin
    push_en    = cmd_i.sc_wr | cmd_i.pr_wr;
    push_large = cmd_i.sc_wr ? (div_q >= OneP) : (pnew >= OneP);
    push_val   = cmd_i.sc_wr ? idx_a : l_rd_q;
    pop_small  = cmd_i.pr_qrd | (cmd_i.dr_qrd & l_empty);
    pop_large  = cmd_i.pr_qrd | (cmd_i.dr_qrd & ~l_empty);
  end

  atb_div #(
    .DW(DW),
    .QW(PW),
    .SW(SW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(DW'(prod_q) << FRACTION_BITS),
    .divisor_i (sum_q),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      sh_q    <= '0;
      st_q    <= '0;
      lh_q    <= '0;
      lt_q    <= '0;
      shs_q   <= '0;
      sts_q   <= '0;
      lhs_q   <= '0;
      lts_q   <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      sh_q    <= '0;
      st_q    <= '0;
      lh_q    <= '0;
      lt_q    <= '0;
      shs_q   <= '0;
      sts_q   <= '0;
      lhs_q   <= '0;
      lts_q   <= '0;
    end else begin
      if (cmd_i.load_fire) begin
        sum_q <= sum_d;
        if (store) count_q <= count_q + CW'(1);
        else ovf_q <= 1'b1;
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + CW'(1);
      if (push_en && !push_large) begin
        st_q  <= st_q + QPW'(1);
        sts_q <= slot_inc(st_q, sts_q);
      end
      if (push_en && push_large) begin
        lt_q  <= lt_q + QPW'(1);
        lts_q <= slot_inc(lt_q, lts_q);
      end
      if (pop_small) begin
        sh_q  <= sh_q + QPW'(1);
        shs_q <= slot_inc(sh_q, shs_q);
      end
      if (pop_large) begin
        lh_q  <= lh_q + QPW'(1);
        lhs_q <= slot_inc(lh_q, lhs_q);
      end
    end
  end

  // Weight store and scaling product
  always_ff @(posedge clk_i) begin
    if (store) wmem[count_q[IW-1:0]] <= weight_i;
    if (cmd_i.w_rd) w_rd_q <= wmem[idx_a];
    if (cmd_i.mul) prod_q <= atb_pkg::ProdW'(w_rd_q * count_q);
  end

  // Probability store: write at scale or pair, read two at pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_wr) pmem[idx_a] <= div_q;
    else if (cmd_i.pr_wr) pmem[l_rd_q] <= pnew;
    if (cmd_i.pr_prd) begin
      ps_q <= pmem[s_rd_q];
      pl_q <= pmem[l_rd_q];
    end
  end

  // Small and large queues
  always_ff @(posedge clk_i) begin
    if (push_en && !push_large) smem[sts_q] <= push_val;
    if (push_en && push_large) lmem[lts_q] <= push_val;
    if (cmd_i.pr_qrd || cmd_i.dr_qrd) begin
      s_rd_q        <= smem[shs_q];
      l_rd_q        <= lmem[lhs_q];
      drain_large_q <= ~l_empty;
    end
  end

  // Threshold and alias tables
  always_ff @(posedge clk_i) begin
    if (cmd_i.pr_wr) begin
      tmem[s_rd_q] <= to_thr(ps_q);
      amem[s_rd_q] <= l_rd_q;
    end else if (cmd_i.dr_wr) begin
      tmem[drain_e] <= to_thr(OneP);
      amem[drain_e] <= drain_e;
    end
    if (cmd_i.em_rd) begin
      t_rd_q <= tmem[idx_a];
      a_rd_q <= amem[idx_a];
    end
  end

  always_comb begin
    sts_o.last_in     = last_weight_i;
    sts_o.sum_zero    = (sum_acc == '0);
    sts_o.idx_last    = (idx_q == count_q - CW'(1));
    sts_o.div_done    = div_done;
    sts_o.small_empty = s_empty;
    sts_o.large_empty = l_empty;
  end

  // Result fields
  always_comb begin
    entry_index_o = cmd_i.zero_out ? '0 : atb_pkg::IdxOutW'(idx_q);
    threshold_o   = cmd_i.zero_out ? '0 : t_rd_q;
    alias_index_o = cmd_i.zero_out ? '0 : atb_pkg::IdxOutW'(a_rd_q);
    last_entry_o  = cmd_i.zero_out ? 1'b1 : sts_o.idx_last;
    all_zero_o    = cmd_i.zero_out;
    overflowed_o  = ovf_q;
  end

endmodule

FILE: rtl/core/atb_ctrl.sv
module atb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  atb_pkg::sts_t sts_i,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  output atb_pkg::cmd_t cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);

  localparam logic [3:0] SLoad  = 4'd0;
  localparam logic [3:0] SScRd  = 4'd1;
  localparam logic [3:0] SScMul = 4'd2;
  localparam logic [3:0] SScDst = 4'd3;
  localparam logic [3:0] SScDiv = 4'd4;
  localparam logic [3:0] SScWr  = 4'd5;
  localparam logic [3:0] SPrChk = 4'd6;
  localparam logic [3:0] SPrQ   = 4'd7;
  localparam logic [3:0] SPrP   = 4'd8;
  localparam logic [3:0] SPrWr  = 4'd9;
  localparam logic [3:0] SDrQ   = 4'd10;
  localparam logic [3:0] SDrWr  = 4'd11;
  localparam logic [3:0] SEmRd  = 4'd12;
  localparam logic [3:0] SEmOut = 4'd13;
  localparam logic [3:0] SZero  = 4'd14;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SLoad;
    else state_q <= state_d;
  end

  // Sequence load, scale, pair, drain and emit, or a single all-zero result
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      SLoad: begin
        in_ready_o      = 1'b1;
        cmd_o.load_fire = in_valid_i;
        if (in_valid_i && sts_i.last_in) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = sts_i.sum_zero ? SZero : SScRd;
        end
      end
      SScRd: begin
        cmd_o.w_rd = 1'b1;
        state_d    = SScMul;
      end
      SScMul: begin
        cmd_o.mul = 1'b1;
        state_d   = SScDst;
      end
      SScDst: begin
        cmd_o.div_start = 1'b1;
        state_d         = SScDiv;
      end
      SScDiv: begin
        if (sts_i.div_done) state_d = SScWr;
      end
      SScWr: begin
        cmd_o.sc_wr = 1'b1;
        if (sts_i.idx_last) begin
          state_d = SPrChk;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = SScRd;
        end
      end
      SPrChk: begin
        if (!sts_i.small_empty && !sts_i.large_empty) begin
          state_d = SPrQ;
        end else if (sts_i.small_empty && sts_i.large_empty) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = SEmRd;
        end else begin
          state_d = SDrQ;
        end
      end
      SPrQ: begin
        cmd_o.pr_qrd = 1'b1;
        state_d      = SPrP;
      end
      SPrP: begin
        cmd_o.pr_prd = 1'b1;
        state_d      = SPrWr;
      end
      SPrWr: begin
        cmd_o.pr_wr = 1'b1;
        state_d     = SPrChk;
      end
      SDrQ: begin
        cmd_o.dr_qrd = 1'b1;
        state_d      = SDrWr;
      end
      SDrWr: begin
        cmd_o.dr_wr = 1'b1;
        state_d     = SPrChk;
      end
      SEmRd: begin
        cmd_o.em_rd = 1'b1;
        state_d     = SEmOut;
      end
      SEmOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.idx_last) begin
            cmd_o.clear = 1'b1;
            state_d     = SLoad;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = SEmRd;
          end
        end
      end
      SZero: begin
        out_valid_o    = 1'b1;
        cmd_o.zero_out = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d     = SLoad;
        end
      end
      default: state_d = SLoad;
    endcase
  end

endmodule

FILE: rtl/core/alias_table_builder_unit.sv
// Weights transfer one per cycle while loading. After the last weight, scaling reads each
// weight, multiplies it by the count, divides by the sum in the bit-serial divider and
// writes the probability; a queue pairing step reads the queue heads, then both probabilities,
// then writes; a drain step reads a queue and writes; then each entry is read and emitted.
// One table is built at a time; the next weight is taken after the last result transfers.
// Reset (rst_ni low, asynchronous) clears count, sum, overflow flag and queue pointers;
// the tables need no clearing and the block takes weights right after reset.
module alias_table_builder_unit #(
  parameter int MAX_ENTRIES   = atb_pkg::MaxEntriesDef,
  parameter int FRACTION_BITS = atb_pkg::FracBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  atb_in_if.sink    in_ch,
  atb_out_if.source out_ch
);

  atb_pkg::cmd_t cmd;
  atb_pkg::sts_t sts;

  atb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sts_i      (sts),
    .in_valid_i (in_ch.valid),
    .out_ready_i(out_ch.ready),
    .cmd_o      (cmd),
    .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid)
  );

  atb_datapath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .weight_i     (in_ch.weight),
    .last_weight_i(in_ch.last_weight),
    .entry_index_o(out_ch.entry_index),
    .threshold_o  (out_ch.threshold),
    .alias_index_o(out_ch.alias_index),
    .last_entry_o (out_ch.last_entry),
    .all_zero_o   (out_ch.all_zero),
    .overflowed_o (out_ch.overflowed)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int Entries = atb_pkg::MaxEntriesDef;
  localparam int Frac    = atb_pkg::FracBitsDef;

  typedef struct packed {
    logic [atb_pkg::IdxOutW-1:0] entry_index;
    logic [atb_pkg::ThrW-1:0]    threshold;
    logic [atb_pkg::IdxOutW-1:0] alias_index;
    logic                        last_entry;
    logic                        all_zero;
    logic                        overflowed;
  } table_entry_t;

  logic clk_i;
  logic rst_ni;
  int   err_cnt;

  atb_in_if  in_ch ();
  atb_out_if out_ch ();

  alias_table_builder_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Model state for the table being collected
  logic [atb_pkg::WeightW-1:0] held_weight [Entries];
  int unsigned                 held_count;
  logic [atb_pkg::SumW-1:0]    held_sum;
  logic                        held_ovf;
  table_entry_t                table_exp_q[$];

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Build the alias table for the held weights and queue its entries
  task automatic build_expected_table();
    longint unsigned          one;
    longint unsigned          prob [Entries];
    logic [atb_pkg::ThrW+8:0] thr [Entries];
    int                       ali [Entries];
    int                       sq[$];
    int                       lq[$];
    int                       s;
    int                       l;
    table_entry_t             e;
    one = longint'(1) << Frac;
    if (held_sum == 0 || held_count == 0) begin
      e = '0;
      e.last_entry = 1'b1;
      e.all_zero   = 1'b1;
      e.overflowed = held_ovf;
      table_exp_q = {table_exp_q, e};
      return;
    end
    for (int i = 0; i < held_count; i++) begin
      prob[i] = ((longint'(held_weight[i]) * held_count) << Frac) / held_sum;
      if (prob[i] < one) sq = {sq, i};
      else lq = {lq, i};
    end
    while (sq.size() > 0 && lq.size() > 0) begin
      s = sq.pop_front();
      l = lq.pop_front();
      thr[s] = (atb_pkg::ThrW + 9)'(prob[s]);
      ali[s] = l;
      prob[l] = prob[l] + prob[s] - one;
      if (prob[l] < one) sq = {sq, l};
      else lq = {lq, l};
    end
    while (lq.size() > 0) begin
      l = lq.pop_front();
      thr[l] = (atb_pkg::ThrW + 9)'(one);
      ali[l] = l;
    end
    while (sq.size() > 0) begin
      s = sq.pop_front();
      thr[s] = (atb_pkg::ThrW + 9)'(one);
      ali[s] = s;
    end
    for (int i = 0; i < held_count; i++) begin
      e.entry_index = atb_pkg::IdxOutW'(i);
      e.threshold   = atb_pkg::ThrW'(thr[i] >> (Frac - 16));
      e.alias_index = atb_pkg::IdxOutW'(ali[i]);
      e.last_entry  = (i + 1 == held_count);
      e.all_zero    = 1'b0;
      e.overflowed  = held_ovf;
      table_exp_q = {table_exp_q, e};
    end
  endtask

  // Send one weight and update the model on transfer
  task automatic send_weight(input logic [atb_pkg::WeightW-1:0] w, input logic last);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 14));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.weight      <= w;
    in_ch.last_weight <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    if (held_count < Entries) begin
      held_weight[held_count] = w;
      held_count++;
      held_sum = held_sum + w;
    end else begin
      held_ovf = 1'b1;
    end
    if (last) begin
      build_expected_table();
      held_count = 0;
      held_sum   = '0;
      held_ovf   = 1'b0;
    end
  endtask

  // Drop valid and hold until every expected result has transferred
  task automatic wait_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    wait (table_exp_q.size() == 0);
  endtask

  task automatic send_table(input int n, input int mode);
    logic [atb_pkg::WeightW-1:0] w;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = atb_pkg::WeightW'($urandom_range(0, 65535));
        1: w = atb_pkg::WeightW'($urandom_range(0, 15));
        2: w = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
               atb_pkg::WeightW'($urandom_range(0, 3));
        default: w = '0;
      endcase
      send_weight(w, i == n - 1);
    end
  endtask

  task automatic test_directed();
    send_weight(16'hFFFF, 1'b1);
    send_weight(16'h0000, 1'b1);
    send_weight(16'h0001, 1'b0);
    send_weight(16'hFFFF, 1'b1);
    send_table(3, 3);
    send_weight(16'h5555, 1'b0);
    send_weight(16'hAAAA, 1'b0);
    send_weight(16'h0003, 1'b1);
  endtask

  task automatic test_overflow();
    // Full capacity of maximum weights, then a dropped last weight
    for (int i = 0; i < Entries; i++) send_weight(16'hFFFF, 1'b0);
    send_weight(16'h1234, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    int tables;
    sent   = 0;
    tables = 0;
    while (sent < 55) begin
      int n;
      n = $urandom_range(1, 8);
      send_table(n, $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0);
      sent += n;
      // Every fourth table, hold off until it is drained
      if (tables % 4 == 0) wait_results();
      tables++;
    end
  endtask

  // Random backpressure on the result side, drawn per result
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 14)) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      table_entry_t e;
      if (table_exp_q.size() == 0) begin
        $error("unexpected result index=%0d", out_ch.entry_index);
        err_cnt++;
      end else begin
        e = table_exp_q.pop_front();
        if (out_ch.entry_index !== e.entry_index) begin
          $error("entry_index exp %0d got %0d", e.entry_index, out_ch.entry_index);
          err_cnt++;
        end
        if (out_ch.threshold !== e.threshold) begin
          $error("threshold exp %0d got %0d", e.threshold, out_ch.threshold);
          err_cnt++;
        end
        if (out_ch.alias_index !== e.alias_index) begin
          $error("alias_index exp %0d got %0d", e.alias_index, out_ch.alias_index);
          err_cnt++;
        end
        if (out_ch.last_entry !== e.last_entry) begin
          $error("last_entry exp %0d got %0d", e.last_entry, out_ch.last_entry);
          err_cnt++;
        end
        if (out_ch.all_zero !== e.all_zero) begin
          $error("all_zero exp %0d got %0d", e.all_zero, out_ch.all_zero);
          err_cnt++;
        end
        if (out_ch.overflowed !== e.overflowed) begin
          $error("overflowed exp %0d got %0d", e.overflowed, out_ch.overflowed);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    err_cnt           = 0;
    held_count        = 0;
    held_sum          = '0;
    held_ovf          = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.weight      = '0;
    in_ch.last_weight = 1'b0;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_random();
    wait_results();
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && table_exp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
